@@ design/ntid_pkg.sv @@
// Shared constants, codes and controller/datapath types for the name-to-id table.
`timescale 1ns / 1ps
package ntid_pkg;

    localparam int TABLE_SIZE = 64;   // power of two: home slot is the low hash bits
    localparam int KEY_BYTES  = 8;
    localparam int ID_BITS    = 7;

    localparam int KEY_W   = 64;
    localparam int TID_W   = 7;
    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam int BIDX_W  = 4;

    localparam logic [31:0] HASH_SEED  = 32'd73;
    localparam int          HASH_SHIFT = 5;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PREP,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic idle;
        logic load;
        logic hash_en;
        logic scan_init;
        logic scan_en;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic hash_done;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

@@ design/ntid_if.sv @@
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface ntid_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [ntid_pkg::KEY_W-1:0] key;
    logic [ntid_pkg::TID_W-1:0] tid;

    modport source (output valid, req_type, key, tid, input ready);
    modport sink   (input valid, req_type, key, tid, output ready);
endinterface

interface ntid_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [ntid_pkg::TID_W-1:0] found_tid;

    modport source (output valid, status, found_tid, input ready);
    modport sink   (input valid, status, found_tid, output ready);
endinterface

@@ design/ntid_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ntid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/ntid_ctrl.sv @@
// Sequencing state machine: hash, probe scan, commit.
`timescale 1ns / 1ps
module ntid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  ntid_pkg::t_dp_sts i_sts,
    output ntid_pkg::t_dp_cmd o_cmd
);
    import ntid_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_HASH;
            end
            S_HASH: begin
                if (i_sts.hash_done) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                o_cmd.load = i_req_valid;
            end
            S_HASH: begin
                o_cmd.hash_en = 1'b1;
            end
            S_PREP: begin
                o_cmd.scan_init = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

@@ design/ntid_dp.sv @@
// Datapath: key capture, byte-serial hash, pipelined probe scan, table update, result register.
`timescale 1ns / 1ps
module ntid_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ntid_pkg::t_dp_cmd          i_cmd,
    output ntid_pkg::t_dp_sts          o_sts,
    input  logic [1:0]                 i_req_type,
    input  logic [ntid_pkg::KEY_W-1:0] i_key,
    input  logic [ntid_pkg::TID_W-1:0] i_tid,
    input  logic                       i_rsp_ready,
    output logic                       o_rsp_valid,
    output logic [1:0]                 o_rsp_status,
    output logic [ntid_pkg::TID_W-1:0] o_rsp_found_tid
);
    import ntid_pkg::*;

    // transaction payload
    logic [1:0]         r_req;
    logic [KEY_W-1:0]   r_key;
    logic [ID_BITS-1:0] r_tid;
    logic [31:0]        r_h;
    logic [BIDX_W-1:0]  r_bidx;

    // scan
    logic [IDX_W-1:0]   r_probe_idx;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_cmp_vld;
    logic               n_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_have_match;
    logic               r_have_empty;
    logic [IDX_W-1:0]   r_match_idx;
    logic [IDX_W-1:0]   r_empty_idx;
    logic [ID_BITS-1:0] r_match_id;

    // table occupancy, result register
    logic [TABLE_SIZE-1:0] r_slot_vld;
    logic [TABLE_SIZE-1:0] n_slot_vld;
    logic                  r_out_vld;
    logic                  n_out_vld;
    logic [1:0]            r_out_status;
    logic [ID_BITS-1:0]    r_out_tid;

    logic [KEY_W-1:0]   w_nkey;
    logic [7:0]         w_byte;
    logic [31:0]        w_h_next;
    logic               w_scan_more;
    logic [IDX_W-1:0]   w_probe_next;
    logic               w_cmp;
    logic               w_match;
    logic               w_empty;
    logic [KEY_W-1:0]   w_rd_name;
    logic [ID_BITS-1:0] w_rd_id;
    logic               w_we;
    logic [IDX_W-1:0]   w_target;
    logic [1:0]         w_status;
    logic [ID_BITS-1:0] w_ftid;

    // keep bytes up to the first zero byte
    always_comb begin
        logic live;
        live   = 1'b1;
        w_nkey = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (i_key[8*i +: 8] == 8'd0) live = 1'b0;
            if (live) w_nkey[8*i +: 8] = i_key[8*i +: 8];
        end
    end

    // one byte per cycle; past the last key byte the terminator is implied
    assign w_byte   = r_bidx[3] ? 8'd0 : r_key[{r_bidx[2:0], 3'b000} +: 8];
    assign w_h_next = (r_h << HASH_SHIFT) + r_h + {24'd0, w_byte};

    assign w_scan_more  = (r_cnt != CNT_W'(TABLE_SIZE));
    assign w_probe_next = (r_probe_idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : r_probe_idx + 1'b1;
    assign n_cmp_vld    = i_cmd.scan_en && w_scan_more;

    assign w_cmp   = i_cmd.scan_en && r_cmp_vld;
    assign w_match = w_cmp && r_slot_vld[r_cmp_idx] && (w_rd_name == r_key);
    assign w_empty = w_cmp && !r_slot_vld[r_cmp_idx];

    assign o_sts.hash_done = (w_byte == 8'd0);
    assign o_sts.scan_done = w_match || (!w_scan_more && !r_cmp_vld);
    assign o_sts.out_free  = !r_out_vld || i_rsp_ready;

    ntid_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_target),
        .i_wdata (r_key),
        .i_raddr (r_probe_idx),
        .o_rdata (w_rd_name)
    );

    ntid_ram #(.WIDTH(ID_BITS), .DEPTH(TABLE_SIZE)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_target),
        .i_wdata (r_tid),
        .i_raddr (r_probe_idx),
        .o_rdata (w_rd_id)
    );

    // first empty slot in probe order wins; with a match it is the freed slot
    // unless an empty one came earlier
    assign w_target = r_have_empty ? r_empty_idx : r_match_idx;

    always_comb begin
        w_status   = ST_NOT_FOUND;
        w_ftid     = '0;
        w_we       = 1'b0;
        n_slot_vld = r_slot_vld;
        case (r_req)
            REQ_LOOKUP: begin
                if (r_have_match) begin
                    w_status = ST_OK;
                    w_ftid   = r_match_id;
                end
            end
            REQ_ADD: begin
                if (!r_have_match && !r_have_empty) begin
                    w_status = ST_FULL;
                end else begin
                    w_status = ST_OK;
                    if (r_have_match) n_slot_vld[r_match_idx] = 1'b0;
                    if (r_key != '0) begin
                        w_we                 = i_cmd.commit;
                        n_slot_vld[w_target] = 1'b1;
                    end
                end
            end
            REQ_REMOVE: begin
                if (r_have_match) begin
                    w_status                = ST_OK;
                    n_slot_vld[r_match_idx] = 1'b0;
                end
            end
            default: begin
                w_status = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
            r_out_vld  <= 1'b0;
            r_cmp_vld  <= 1'b0;
        end else begin
            if (i_cmd.commit) r_slot_vld <= n_slot_vld;
            r_out_vld <= n_out_vld;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_key  <= w_nkey;
            r_tid  <= i_tid[ID_BITS-1:0];
            r_h    <= HASH_SEED;
            r_bidx <= '0;
        end else if (i_cmd.hash_en) begin
            r_h    <= w_h_next;
            r_bidx <= r_bidx + 1'b1;
        end

        if (i_cmd.scan_init) begin
            r_probe_idx  <= r_h[IDX_W-1:0];
            r_cnt        <= '0;
            r_have_match <= 1'b0;
            r_have_empty <= 1'b0;
        end else if (i_cmd.scan_en) begin
            if (w_scan_more) begin
                r_probe_idx <= w_probe_next;
                r_cnt       <= r_cnt + 1'b1;
                r_cmp_idx   <= r_probe_idx;
            end
            if (w_match) begin
                r_have_match <= 1'b1;
                r_match_idx  <= r_cmp_idx;
                r_match_id   <= w_rd_id;
            end
            if (w_empty && !r_have_empty) begin
                r_have_empty <= 1'b1;
                r_empty_idx  <= r_cmp_idx;
            end
        end

        if (i_cmd.commit) begin
            r_out_status <= w_status;
            r_out_tid    <= w_ftid;
        end
    end

    assign o_rsp_valid     = r_out_vld;
    assign o_rsp_status    = r_out_status;
    assign o_rsp_found_tid = TID_W'(r_out_tid);
endmodule

@@ design/name_to_id_linear_probe_table_top.sv @@
// Top level of the name-to-id table: controller, datapath and channel hookup.
// Per transaction: byte-serial hash of the name (at most 8 bytes) plus terminator, a setup
// step, a scan of one slot per cycle from the home slot until a match or the whole table is
// seen, and a commit that waits while an earlier result is held. One transaction at a time:
// the next is taken the cycle after the result is registered, while it may still wait.
// Synchronous active-low reset empties the table, resets the controller and clears the result and compare valid flags.
`timescale 1ns / 1ps
module name_to_id_linear_probe_table_top (
    input logic      i_clk,
    input logic      i_rst_n,
    ntid_req_if.sink i_req,
    ntid_rsp_if.source o_rsp
);
    import ntid_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ntid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ntid_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_req_type      (i_req.req_type),
        .i_key           (i_req.key),
        .i_tid           (i_req.tid),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_rsp_status    (o_rsp.status),
        .o_rsp_found_tid (o_rsp.found_tid)
    );

    assign i_req.ready = w_cmd.idle;
endmodule

@@ design/ntid_checker.sv @@
// Port-level checker for the name-to-id table, bound to the top level.
`timescale 1ns / 1ps
module ntid_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [1:0]                 i_rsp_status,
    input logic [ntid_pkg::TID_W-1:0] i_rsp_found_tid
);
    import ntid_pkg::*;

    // a held result keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_found_tid))
        else $error("response changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_OK || i_rsp_status == ST_NOT_FOUND ||
                         i_rsp_status == ST_FULL))
        else $error("undefined status code");

    a_tid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_found_tid == '0)
        else $error("found_tid nonzero on failed transaction");

    // the table works on one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");
endmodule

bind name_to_id_linear_probe_table_top ntid_checker u_ntid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_found_tid (o_rsp.found_tid)
);
